### sv/wmmv3d_pkg.sv
`timescale 1ns / 1ps

package wmmv3d_pkg;

    localparam int KERNEL_SIZE_DEF = 3;
    localparam int MAX_WIDTH_DEF   = 256;
    localparam int MAX_HEIGHT_DEF  = 256;
    localparam int MAX_DEPTH       = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 4;
    localparam int WVEC_W     = 108;
    localparam int WLOW_W     = 64;
    localparam int WHIGH_W    = 44;
    localparam int DIM_W      = 9;
    localparam int DEPTH_W    = 13;
    localparam int CX_W       = 8;
    localparam int CY_W       = 8;
    localparam int CZ_W       = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int PROD_W  = 21;
    localparam int SQ_W    = 40;
    localparam int SUM_W   = 26;
    localparam int SUM2_W  = 44;
    localparam int WSUM_W  = 9;
    localparam int WS2_W   = 52;
    localparam int SS_W    = 48;
    localparam int ABS_W   = 24;
    localparam int FRAC_W  = 8;
    localparam int NUM_W   = 60;
    localparam int DEN_W   = 18;
    localparam int VALUE_W = 52;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_WIDTH  = 3'd1,
        CFG_HEIGHT = 3'd2,
        CFG_DEPTH  = 3'd3,
        CFG_WLOW   = 3'd4,
        CFG_WHIGH  = 3'd5
    } cfg_reg_t;

    // Partial sums that ripple down the cell chain.
    typedef struct packed {
        logic                     vld;
        logic signed [SUM_W-1:0]  s;
        logic        [SUM2_W-1:0] s2;
        logic        [WSUM_W-1:0] ws;
    } acc_t;

endpackage

### sv/wmmv3d_ifs.sv
`timescale 1ns / 1ps

interface wmmv3d_in_if import wmmv3d_pkg::*; ;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface wmmv3d_out_if import wmmv3d_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [CX_W-1:0]           center_x;
    logic [CY_W-1:0]           center_y;
    logic [CZ_W-1:0]           center_z;
    logic                      weight_sum_zero;
    logic                      last;

    modport source (output valid, output value, output center_x, output center_y,
                    output center_z, output weight_sum_zero, output last, input ready);
    modport sink (input valid, input value, input center_x, input center_y,
                  input center_z, input weight_sum_zero, input last, output ready);
endinterface

interface wmmv3d_cfg_if import wmmv3d_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/wmmv3d_ram.sv
`timescale 1ns / 1ps

module wmmv3d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/wmmv3d_cell.sv
`timescale 1ns / 1ps

module wmmv3d_cell import wmmv3d_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift_en,
    input  logic signed [SAMPLE_W-1:0] x_in,
    input  logic [WEIGHT_W-1:0]        weight,
    input  acc_t                       acc_in,
    output logic signed [SAMPLE_W-1:0] x_out,
    output acc_t                       acc_out
);

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [PROD_W-1:0]   p_reg;
    logic signed [PROD_W-1:0]   p_next;
    logic [SQ_W-1:0]            q_reg;
    logic signed [2*PROD_W-1:0] sq_full;
    acc_t                       acc_reg;
    acc_t                       acc_next;

    assign p_next  = PROD_W'(x_reg) * PROD_W'(signed'({1'b0, weight}));
    assign sq_full = p_reg * p_reg;

    always_comb
    begin
        acc_next     = acc_reg;
        acc_next.vld = acc_in.vld;
        if (acc_in.vld)
        begin
            acc_next.s  = acc_in.s + SUM_W'(p_reg);
            acc_next.s2 = acc_in.s2 + SUM2_W'(q_reg);
            acc_next.ws = acc_in.ws + WSUM_W'(weight);
        end
    end

    // The weighted sample is registered in p_reg from x_reg, and its square in q_reg from p_reg.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            x_reg <= x_in;
        end
        p_reg <= p_next;
        q_reg <= sq_full[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign x_out   = x_reg;
    assign acc_out = acc_reg;

endmodule

### sv/wmmv3d_div.sv
`timescale 1ns / 1ps

module wmmv3d_div import wmmv3d_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W:0]   rem_reg;
    logic [DEN_W:0]   rem_sh;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;

    // Restoring division, one quotient bit per cycle while busy; the dividend shifts out
    // of quo_reg from the top while quotient bits shift in at the bottom.
    assign rem_sh = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/weighted_moving_mean_variance_3d.sv
`timescale 1ns / 1ps

// Channel | Direction | Word                                             | Handshake
// voxel   | in        | sample                                           | valid/ready
// result  | out       | value, center_x/y/z, weight_sum_zero, last       | valid/ready
// cfg     | in        | index, data                                      | valid/ready
//
// A voxel with no result (border) is stored and not processed further. A voxel that
// completes a window goes through K^3 reads from the sample RAM, K^3 hops along
// the cell chain and the serial divider.
// Reset clears control, position and configuration; the sample RAM is not cleared.
// A finished result waits in the output register while the next voxel is accepted.

module weighted_moving_mean_variance_3d import wmmv3d_pkg::*; #(
    parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    wmmv3d_in_if.sink   voxel,
    wmmv3d_out_if.source result,
    wmmv3d_cfg_if.sink  cfg
);

    localparam int HALF        = KERNEL_SIZE / 2;
    localparam int TAIL        = KERNEL_SIZE - 1 - HALF;
    localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE * KERNEL_SIZE;
    localparam int STORE_DEPTH = (KERNEL_SIZE - 1) * MAX_WIDTH * MAX_HEIGHT
                               + (KERNEL_SIZE - 1) * MAX_WIDTH + KERNEL_SIZE;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int OFF_W       = AW + 1;
    localparam int WMAX        = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
    localparam int HMAX        = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
    localparam int LOAD_END    = TAPS + 4;
    localparam int TC_W        = $clog2(LOAD_END + 1);
    localparam int KC_W        = 2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_SUM   = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_START = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic                mode_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [WLOW_W-1:0]   wlow_reg;
    logic [WHIGH_W-1:0]  whigh_reg;
    logic [WVEC_W-1:0]   wvec;

    logic [DIM_W-1:0]    w_c;
    logic [DIM_W-1:0]    h_c;
    logic [DEPTH_W-1:0]  d_c;
    logic [2*DIM_W-1:0]  wh_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
            depth_reg  <= DEPTH_W'(256);
            wlow_reg   <= 64'h1111_1111_1111_1111;
            whigh_reg  <= 44'h111_1111_1111;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CFG_MODE:   mode_reg   <= cfg.data[0];
                CFG_WIDTH:  width_reg  <= cfg.data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg.data[DIM_W-1:0];
                CFG_DEPTH:  depth_reg  <= cfg.data[DEPTH_W-1:0];
                CFG_WLOW:   wlow_reg   <= cfg.data[WLOW_W-1:0];
                CFG_WHIGH:  whigh_reg  <= cfg.data[WHIGH_W-1:0];
                default:    ;
            endcase
        end
    end

    assign wvec = {whigh_reg, wlow_reg};

    always_comb
    begin
        priority if (width_reg < DIM_W'(3))
            w_c = DIM_W'(3);
        else if (width_reg > DIM_W'(WMAX))
            w_c = DIM_W'(WMAX);
        else
            w_c = width_reg;
        priority if (height_reg < DIM_W'(3))
            h_c = DIM_W'(3);
        else if (height_reg > DIM_W'(HMAX))
            h_c = DIM_W'(HMAX);
        else
            h_c = height_reg;
        priority if (depth_reg < DEPTH_W'(3))
            d_c = DEPTH_W'(3);
        else if (depth_reg > DEPTH_W'(MAX_DEPTH))
            d_c = DEPTH_W'(MAX_DEPTH);
        else
            d_c = depth_reg;
    end

    always_ff @(posedge clk)
    begin
        wh_reg <= w_c * h_c;
    end

    // Position tracking and window test.
    logic [DIM_W-1:0]   x_reg;
    logic [DIM_W-1:0]   y_reg;
    logic [CZ_W-1:0]    z_reg;
    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      item_ptr_reg;
    logic               accept;
    logic               oor;
    logic [DIM_W-1:0]   xe;
    logic [DIM_W-1:0]   ye;
    logic [CZ_W-1:0]    ze;
    logic [DIM_W:0]     x_ext;
    logic [DIM_W:0]     y_ext;
    logic [DEPTH_W:0]   z_ext;
    logic               interior;
    logic               is_last;
    logic [DIM_W:0]     xn;
    logic [DIM_W:0]     yn;
    logic [DEPTH_W-1:0] zn;

    assign accept = voxel.valid && voxel.ready;
    assign voxel.ready = (state_reg == S_IDLE);

    assign oor = (x_reg >= w_c) || (y_reg >= h_c) || ({1'b0, z_reg} >= d_c);
    assign xe  = oor ? '0 : x_reg;
    assign ye  = oor ? '0 : y_reg;
    assign ze  = oor ? '0 : z_reg;

    // Far edge of the window around the center, measured from this voxel.
    assign x_ext = (DIM_W + 1)'(xe) + (DIM_W + 1)'(HALF) - (DIM_W + 1)'(TAIL);
    assign y_ext = (DIM_W + 1)'(ye) + (DIM_W + 1)'(HALF) - (DIM_W + 1)'(TAIL);
    assign z_ext = (DEPTH_W + 1)'(ze) + (DEPTH_W + 1)'(HALF) - (DEPTH_W + 1)'(TAIL);

    assign interior = (xe >= DIM_W'(KERNEL_SIZE - 1)) && (ye >= DIM_W'(KERNEL_SIZE - 1))
                   && (ze >= CZ_W'(KERNEL_SIZE - 1))
                   && (x_ext < (DIM_W + 1)'(w_c)) && (y_ext < (DIM_W + 1)'(h_c))
                   && (z_ext < (DEPTH_W + 1)'(d_c));
    assign is_last = (x_ext + 1'b1 == (DIM_W + 1)'(w_c)) && (y_ext + 1'b1 == (DIM_W + 1)'(h_c))
                  && (z_ext + 1'b1 == (DEPTH_W + 1)'(d_c));

    assign xn = (DIM_W + 1)'(xe) + 1'b1;
    assign yn = (DIM_W + 1)'(ye) + 1'b1;
    assign zn = DEPTH_W'(ze) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            z_reg   <= '0;
            ptr_reg <= '0;
        end
        else if (accept)
        begin
            ptr_reg <= (ptr_reg == AW'(STORE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            if (xn >= (DIM_W + 1)'(w_c))
            begin
                x_reg <= '0;
                if (yn >= (DIM_W + 1)'(h_c))
                begin
                    y_reg <= '0;
                    z_reg <= (zn >= d_c) ? '0 : zn[CZ_W-1:0];
                end
                else
                begin
                    y_reg <= yn[DIM_W-1:0];
                    z_reg <= ze;
                end
            end
            else
            begin
                x_reg <= xn[DIM_W-1:0];
                y_reg <= ye;
                z_reg <= ze;
            end
        end
    end

    // Item fields captured at accept.
    logic [CX_W-1:0] cx_reg;
    logic [CY_W-1:0] cy_reg;
    logic [CZ_W-1:0] cz_reg;
    logic            last_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_ptr_reg <= ptr_reg;
            cx_reg       <= CX_W'(xe - DIM_W'(TAIL));
            cy_reg       <= CY_W'(ye - DIM_W'(TAIL));
            cz_reg       <= CZ_W'(ze - CZ_W'(TAIL));
            last_reg     <= is_last;
        end
    end

    // Tap address sequencer: newest tap first, x fastest.
    logic [TC_W-1:0]  cnt_reg;
    logic [KC_W-1:0]  ax_reg;
    logic [KC_W-1:0]  ay_reg;
    logic [OFF_W-1:0] row_off_reg;
    logic [OFF_W-1:0] plane_off_reg;
    logic [OFF_W-1:0] dist_reg;
    logic             iss_v1_reg;
    logic             rd_v2_reg;
    logic             issue;
    logic [AW-1:0]    raddr;
    logic [SAMPLE_W-1:0] rdata;

    assign issue = (state_reg == S_LOAD) && (cnt_reg < TC_W'(TAPS));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg        <= '0;
            ay_reg        <= '0;
            row_off_reg   <= '0;
            plane_off_reg <= '0;
        end
        else if (issue)
        begin
            if (ax_reg == KC_W'(KERNEL_SIZE - 1))
            begin
                ax_reg <= '0;
                if (ay_reg == KC_W'(KERNEL_SIZE - 1))
                begin
                    ay_reg        <= '0;
                    row_off_reg   <= '0;
                    plane_off_reg <= plane_off_reg + OFF_W'(wh_reg);
                end
                else
                begin
                    ay_reg      <= ay_reg + 1'b1;
                    row_off_reg <= row_off_reg + OFF_W'(w_c);
                end
            end
            else
            begin
                ax_reg <= ax_reg + 1'b1;
            end
        end
        dist_reg <= OFF_W'(ax_reg) + row_off_reg + plane_off_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_v1_reg <= 1'b0;
            rd_v2_reg  <= 1'b0;
        end
        else
        begin
            iss_v1_reg <= issue;
            rd_v2_reg  <= iss_v1_reg;
        end
    end

    always_comb
    begin
        if (OFF_W'(item_ptr_reg) >= dist_reg)
            raddr = AW'(OFF_W'(item_ptr_reg) - dist_reg);
        else
            raddr = AW'(OFF_W'(item_ptr_reg) + OFF_W'(STORE_DEPTH) - dist_reg);
    end

    wmmv3d_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (ptr_reg),
        .wdata (voxel.sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Cell chain: after the load, cell j holds tap TAPS-1-j in read order, so the newest tap sits in the last cell.
    logic signed [SAMPLE_W-1:0] x_link [TAPS+1];
    acc_t                       acc_link [TAPS+1];

    assign x_link[0]   = signed'(rdata);
    assign acc_link[0] = '{vld: (state_reg == S_LOAD) && (cnt_reg == TC_W'(LOAD_END)),
                           s: '0, s2: '0, ws: '0};

    for (genvar j = 0; j < TAPS; j++)
    begin : g_cell
        wmmv3d_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (rd_v2_reg),
            .x_in     (x_link[j]),
            .weight   (wvec[WEIGHT_W*j +: WEIGHT_W]),
            .acc_in   (acc_link[j]),
            .x_out    (x_link[j+1]),
            .acc_out  (acc_link[j+1])
        );
    end

    // Products and division.
    logic signed [SUM_W-1:0]          s_reg;
    logic [SUM2_W-1:0]                s2_reg;
    logic [WSUM_W-1:0]                ws_reg;
    logic [WSUM_W+SUM2_W-1:0]         ws_s2_full;
    logic signed [2*SUM_W-1:0]        ss_full;
    logic [2*WSUM_W-1:0]              ww_full;
    logic [SUM_W-1:0]                 abs_full;
    logic [WS2_W-1:0]                 ws_s2_reg;
    logic [SS_W-1:0]                  ss_reg;
    logic [DEN_W-1:0]                 ww_reg;
    logic [ABS_W-1:0]                 abs_s_reg;
    logic                             neg_reg;
    logic                             zero_reg;
    logic [WS2_W-1:0]                 var_num;
    logic [NUM_W-1:0]                 dividend;
    logic [DEN_W-1:0]                 divisor;
    logic                             div_start;
    logic                             div_done;
    logic [NUM_W-1:0]                 div_quo;
    logic [VALUE_W-1:0]               q_low;
    logic signed [VALUE_W-1:0]        val_reg;

    assign ws_s2_full = ws_reg * s2_reg;
    assign ss_full    = s_reg * s_reg;
    assign ww_full    = ws_reg * ws_reg;
    assign abs_full   = s_reg[SUM_W-1] ? SUM_W'(-s_reg) : SUM_W'(s_reg);

    // W*S2 - S*S is never negative, so only the mean needs a sign fix.
    assign var_num  = ws_s2_reg - WS2_W'(ss_reg);
    assign dividend = mode_reg ? NUM_W'({var_num, FRAC_W'(0)})
                               : NUM_W'({abs_s_reg, FRAC_W'(0)});
    assign divisor  = mode_reg ? ww_reg : DEN_W'(ws_reg);
    assign div_start = (state_reg == S_START);
    assign q_low     = div_quo[VALUE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (acc_link[TAPS].vld)
        begin
            s_reg  <= acc_link[TAPS].s;
            s2_reg <= acc_link[TAPS].s2;
            ws_reg <= acc_link[TAPS].ws;
        end
        if (state_reg == S_MUL)
        begin
            ws_s2_reg <= ws_s2_full[WS2_W-1:0];
            ss_reg    <= ss_full[SS_W-1:0];
            ww_reg    <= ww_full;
            abs_s_reg <= abs_full[ABS_W-1:0];
            neg_reg   <= s_reg[SUM_W-1] & ~mode_reg;
            zero_reg  <= (ws_reg == '0);
        end
        if (div_done)
        begin
            if (zero_reg)
                val_reg <= '0;
            else if (neg_reg)
                val_reg <= signed'(-q_low);
            else
                val_reg <= signed'(q_low);
        end
    end

    wmmv3d_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Output register.
    logic                      out_v_reg;
    logic signed [VALUE_W-1:0] out_val_reg;
    logic [CX_W-1:0]           out_cx_reg;
    logic [CY_W-1:0]           out_cy_reg;
    logic [CZ_W-1:0]           out_cz_reg;
    logic                      out_zero_reg;
    logic                      out_last_reg;
    logic                      out_load;

    assign out_load = (state_reg == S_DONE) && (!out_v_reg || result.ready);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_val_reg  <= val_reg;
            out_cx_reg   <= cx_reg;
            out_cy_reg   <= cy_reg;
            out_cz_reg   <= cz_reg;
            out_zero_reg <= zero_reg;
            out_last_reg <= last_reg;
        end
    end

    assign result.valid           = out_v_reg;
    assign result.value           = out_val_reg;
    assign result.center_x        = out_cx_reg;
    assign result.center_y        = out_cy_reg;
    assign result.center_z        = out_cz_reg;
    assign result.weight_sum_zero = out_zero_reg;
    assign result.last            = out_last_reg;

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_v_reg <= 1'b1;
            else if (result.ready)
                out_v_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept && interior)
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == TC_W'(LOAD_END))
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (acc_link[TAPS].vld)
                        state_reg <= S_MUL;
                end
                S_MUL:   state_reg <= S_START;
                S_START: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_sum_in_sum_state: assert property (@(posedge clk) disable iff (!rst_n)
        acc_link[TAPS].vld |-> state_reg == S_SUM)
        else $error("partial sums left the chain outside the sum phase");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished while not awaited");

    a_zero_weight_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.weight_sum_zero) |-> result.value == '0)
        else $error("zero weight sum with nonzero value");
`endif

endmodule
